>>> sv/kat_pkg.sv
// Shared codes and controller/datapath command and status types for the keyed accumulator table.
package kat_pkg;

    localparam int KEY_W    = 64;
    localparam int AMT_W    = 32;
    localparam int VAL_W    = 40;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 80;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ACCUM    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    // -1.0 in Q32.8
    localparam logic signed [VAL_W-1:0] THRESHOLD = -40'sd256;
    localparam logic signed [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [1:0] SRC_SUM  = 2'd0;
    localparam logic [1:0] SRC_NEW  = 2'd1;
    localparam logic [1:0] SRC_MOVE = 2'd2;

    typedef struct packed {
        logic                req_load;
        logic                rd_en;
        logic                key_cmp;
        logic                arg_cmp;
        logic                best_clr;
        logic                wr_en;
        logic                wr_at_hit;
        logic [1:0]          wr_src;
        logic                load_out;
        logic [STATUS_W-1:0] out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic key_eq;
        logic out_free;
    } t_dp_sts;

endpackage

>>> sv/kat_ctrl.sv
// Sequencer for the keyed accumulator table: key search, update, argmax walk, result hand-off.
module kat_ctrl #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6,
    parameter int CW      = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    input  logic [kat_pkg::OP_W-1:0] i_op,
    input  kat_pkg::t_dp_sts       i_sts,
    output kat_pkg::t_dp_cmd       o_cmd,
    output logic [AW-1:0]          o_rd_addr,
    output logic [AW-1:0]          o_wr_addr,
    output logic [CW-1:0]          o_count
);
    import kat_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_ARG  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_occ, n_occ;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_hit, n_hit;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0]       occ_m1;

    assign occ_m1      = r_occ - 1'b1;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_count     = r_occ;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_occ     = r_occ;
        n_cmp_vld = 1'b0;
        n_hit     = r_hit;
        n_status  = r_status;
        o_cmd     = '0;
        o_rd_addr = r_cnt[AW-1:0];
        o_wr_addr = r_occ[AW-1:0];
        o_cmd.out_status = r_status;

        unique case (r_state)
            S_IDLE: begin
                o_cmd.best_clr = 1'b1;
                if (i_req_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_op  = i_op;
                    n_cnt = '0;
                    n_hit = 1'b0;
                    unique case (i_op)
                        OP_ADD, OP_REMOVE: n_state = S_SCAN;
                        OP_CLEAR: begin
                            n_occ    = '0;
                            n_status = ST_CLEARED;
                            n_state  = S_ARG;
                        end
                        default: begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_ARG;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.key_cmp = r_cmp_vld;
                priority if (r_cmp_vld && i_sts.key_eq) begin
                    n_hit   = 1'b1;
                    n_state = S_ACT;
                end else if (r_cnt == r_occ) begin
                    // last compare has drained with no match
                    if (!r_cmp_vld) begin
                        n_state = S_ACT;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    n_cmp_vld   = 1'b1;
                end
            end
            S_ACT: begin
                n_cnt   = '0;
                n_state = S_ARG;
                if (r_op == OP_ADD) begin
                    priority if (r_hit) begin
                        o_cmd.wr_en     = 1'b1;
                        o_cmd.wr_at_hit = 1'b1;
                        o_cmd.wr_src    = SRC_SUM;
                        n_status        = ST_ACCUM;
                    end else if (r_occ != CW'(ENTRIES)) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_src = SRC_NEW;
                        n_occ        = r_occ + 1'b1;
                        n_status     = ST_INSERT;
                    end else begin
                        n_status = ST_FULL;
                    end
                end else if (r_hit) begin
                    // fetch the last entry to fill the freed slot
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = occ_m1[AW-1:0];
                    n_status    = ST_REMOVED;
                    n_state     = S_MOVE;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            S_MOVE: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_at_hit = 1'b1;
                o_cmd.wr_src    = SRC_MOVE;
                n_occ           = occ_m1;
                n_state         = S_ARG;
            end
            S_ARG: begin
                o_cmd.arg_cmp = r_cmp_vld;
                if (r_cnt != r_occ) begin
                    o_cmd.rd_en = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    n_cmp_vld   = 1'b1;
                end else if (!r_cmp_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_op      <= OP_ADD;
            r_status  <= ST_NOTFOUND;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_cnt     <= n_cnt;
            r_cmp_vld <= n_cmp_vld;
            r_hit     <= n_hit;
            r_op      <= n_op;
            r_status  <= n_status;
        end
    end

endmodule

>>> sv/kat_dp.sv
// Datapath for the keyed accumulator table: key/value memories, compare, saturating add, argmax, output register.
module kat_dp #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6,
    parameter int CW      = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kat_pkg::t_dp_cmd            i_cmd,
    output kat_pkg::t_dp_sts            o_sts,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [CW-1:0]               i_count,
    input  logic [kat_pkg::KEY_W-1:0]   i_key,
    input  logic signed [kat_pkg::AMT_W-1:0] i_amount,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [kat_pkg::STATUS_W-1:0] o_status,
    output logic [kat_pkg::KEY_W-1:0]   o_top_key,
    output logic                        o_top_found,
    output logic [kat_pkg::COUNT_W-1:0] o_entry_count
);
    import kat_pkg::*;

    logic [KEY_W-1:0] mem_key [ENTRIES];
    logic [VAL_W-1:0] mem_val [ENTRIES];

    logic [KEY_W-1:0]        r_key;
    logic signed [AMT_W-1:0] r_amount;
    logic [KEY_W-1:0]        r_rd_key;
    logic signed [VAL_W-1:0] r_rd_val;
    logic [AW-1:0]           r_rd_addr;
    logic [AW-1:0]           r_hit_idx;
    logic signed [VAL_W-1:0] r_sum;
    logic signed [VAL_W-1:0] r_best;
    logic [KEY_W-1:0]        r_top;
    logic                    r_found;
    logic                    r_out_vld;
    logic [STATUS_W-1:0]     r_out_status;
    logic [KEY_W-1:0]        r_out_key;
    logic                    r_out_found;
    logic [COUNT_W-1:0]      r_out_count;

    logic signed [VAL_W:0]   sum_wide;
    logic signed [VAL_W-1:0] sum_sat;
    logic [AW-1:0]           wr_addr;
    logic [KEY_W-1:0]        wr_key;
    logic [VAL_W-1:0]        wr_val;
    logic [CW+COUNT_W-1:0]   count_wide;

    assign sum_wide = {r_rd_val[VAL_W-1], r_rd_val}
                    + {{(VAL_W+1-AMT_W){r_amount[AMT_W-1]}}, r_amount};

    always_comb begin
        priority if (sum_wide > $signed({VAL_MAX[VAL_W-1], VAL_MAX})) begin
            sum_sat = VAL_MAX;
        end else if (sum_wide < $signed({VAL_MIN[VAL_W-1], VAL_MIN})) begin
            sum_sat = VAL_MIN;
        end else begin
            sum_sat = sum_wide[VAL_W-1:0];
        end
    end

    assign wr_addr = i_cmd.wr_at_hit ? r_hit_idx : i_wr_addr;

    always_comb begin
        unique case (i_cmd.wr_src)
            SRC_SUM: begin
                wr_key = r_key;
                wr_val = r_sum;
            end
            SRC_NEW: begin
                wr_key = r_key;
                wr_val = {{(VAL_W-AMT_W){r_amount[AMT_W-1]}}, r_amount};
            end
            SRC_MOVE: begin
                wr_key = r_rd_key;
                wr_val = r_rd_val;
            end
            default: begin
                wr_key = r_key;
                wr_val = r_sum;
            end
        endcase
    end

    assign o_sts.key_eq   = (r_rd_key == r_key);
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_key[wr_addr] <= wr_key;
            mem_val[wr_addr] <= wr_val;
        end
        if (i_cmd.rd_en) begin
            r_rd_key  <= mem_key[i_rd_addr];
            r_rd_val  <= mem_val[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_key    <= i_key;
            r_amount <= i_amount;
        end
        // capture the matching slot and its updated value
        if (i_cmd.key_cmp && o_sts.key_eq) begin
            r_hit_idx <= r_rd_addr;
            r_sum     <= sum_sat;
        end
        if (i_cmd.best_clr) begin
            r_best  <= THRESHOLD;
            r_top   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.arg_cmp && (r_rd_val > r_best)) begin
            r_best  <= r_rd_val;
            r_top   <= r_rd_key;
            r_found <= 1'b1;
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, i_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            r_out_key    <= r_top;
            r_out_found  <= r_found;
            r_out_count  <= count_wide[COUNT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_top_key     = r_out_key;
    assign o_top_found   = r_out_found;
    assign o_entry_count = r_out_count;

endmodule

>>> sv/keyed_accumulator_table_max.sv
// Keyed accumulator table with argmax: top level joining the sequencer and the datapath.
//
// Slave stream takes one request per handshake: add an amount to a key, remove a
// key, or clear the table. Every request yields exactly one result on the master
// stream: a status, the argmax key with its found flag, and the entry count.
// An add or remove passes through the key search (one read per entry plus the drain
// of the last compare), the update, the argmax walk over the entries left and the
// output load; a clear goes straight to the argmax walk. A hit ends the search
// early; a remove that hits also moves the last entry into the freed slot. After
// the load the sequencer returns to idle, and only there is the next request
// accepted.
// One request is processed at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new request is accepted while the
// previous result still waits; a stalled master side holds the result and keeps
// the next one in the sequencer until the register frees.
// Reset empties the table at once (entry count to zero) and drops any pending
// result; memory contents need no clearing.
module keyed_accumulator_table_max #(
    parameter int ENTRIES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // operation[1:0], key[65:2], amount[97:66], zero pad[103:98]
    input  logic [kat_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // status[2:0], top_key[66:3], top_found[67], entry_count[74:68], zero pad[79:75]
    output logic [kat_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import kat_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [CW-1:0]       count;
    logic [STATUS_W-1:0] out_status;
    logic [KEY_W-1:0]    out_key;
    logic                out_found;
    logic [COUNT_W-1:0]  out_count;

    kat_ctrl #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_op        (i_s_axis_tdata[1:0]),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_count     (count)
    );

    kat_dp #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .CW      (CW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .i_count       (count),
        .i_key         (i_s_axis_tdata[65:2]),
        .i_amount      (i_s_axis_tdata[97:66]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_status      (out_status),
        .o_top_key     (out_key),
        .o_top_found   (out_found),
        .o_entry_count (out_count)
    );

    assign o_m_axis_tdata = {5'b0, out_count, out_found, out_key, out_status};

endmodule

>>> sv/kat_chk.sv
// Port-level checker for the keyed accumulator table, bound to the top level.
module kat_chk #(
    parameter int ENTRIES = 64
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [kat_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [kat_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import kat_pkg::*;

    // reset drops any pending result
    a_reset_drops: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[67] |-> o_m_axis_tdata[66:3] == '0)
        else $error("top key nonzero without a found entry");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2:0] == ST_CLEARED
        |-> o_m_axis_tdata[74:68] == '0 && !o_m_axis_tdata[67])
        else $error("clear left entries behind");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (ENTRIES > 127) || (int'(o_m_axis_tdata[74:68]) <= ENTRIES))
        else $error("entry count above table size");

endmodule

bind keyed_accumulator_table_max kat_chk #(.ENTRIES(ENTRIES)) u_kat_chk (.*);
